/* rtl/bfce_pkg.sv */
`default_nettype none

package bfce_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned ADDR_W    = 10;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned BIT_IDX_W = 13;
  localparam int unsigned COUNT_W   = 14;

  // Request function codes.
  typedef enum logic [1:0] {
    FUNC_WR_SRC = 2'd0,
    FUNC_WR_DST = 2'd1,
    FUNC_RD_DST = 2'd2,
    FUNC_COPY   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PRIME,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prime;
    logic run;
    logic finish;
  } bfce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_copy;
    logic zero_len;
    logic refused;
    logic last_byte;
    logic out_free;
  } bfce_sts_t;

endpackage

`default_nettype wire

/* rtl/bfce_ram.sv */
`default_nettype none

module bfce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/bfce_ctrl.sv */
`default_nettype none

module bfce_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bfce_pkg::bfce_sts_t  sts,
  output bfce_pkg::bfce_cmd_t  cmd
);

  import bfce_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Accesses, empty copies and refused copies go straight to the result.
        if (!sts.is_copy || sts.zero_len || sts.refused) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_PRIME;
        end
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cmd.run = 1'b1;
        if (sts.last_byte) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/bfce_datapath.sv */
`default_nettype none

module bfce_datapath #(
  parameter int STORE_BYTES = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bfce_pkg::bfce_cmd_t              cmd,
  output bfce_pkg::bfce_sts_t              sts,
  input  logic [1:0]                       in_func,
  input  logic [bfce_pkg::ADDR_W-1:0]      in_byte_address,
  input  logic [bfce_pkg::DATA_W-1:0]      in_write_data,
  input  logic [bfce_pkg::BIT_IDX_W-1:0]   in_src_bit_index,
  input  logic [bfce_pkg::BIT_IDX_W-1:0]   in_dst_bit_index,
  input  logic [bfce_pkg::COUNT_W-1:0]     in_bit_count,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [bfce_pkg::DATA_W-1:0]      out_read_data,
  output logic                             out_status
);

  import bfce_pkg::*;

  localparam int          AW         = $clog2(STORE_BYTES);
  localparam logic [31:0] STORE_LIM  = 32'(STORE_BYTES);
  localparam logic [31:0] TOTAL_BITS = 32'(STORE_BYTES) * 32'd8;

  // Latched request.
  func_t                func_r;
  logic                 addr_ok_r;
  logic [BIT_IDX_W-1:0] s_r;
  logic [BIT_IDX_W-1:0] d_r;
  logic [COUNT_W-1:0]   n_r;

  // Walker over destination bytes.
  logic [AW-1:0]        k_r;
  logic [AW-1:0]        a_r;
  logic                 first_r;
  logic [DATA_W-1:0]    prev_r;

  // Write-back stage, registered from the walker and following it in the next cycle.
  logic                 wr_v_r;
  logic [AW-1:0]        wr_k_r;
  logic [DATA_W-1:0]    wr_mask_r;

  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_read_data_r;
  logic                 out_status_r;

  logic                 in_ok;
  logic [AW-1:0]        in_addr;
  logic [COUNT_W:0]     s_end;
  logic [COUNT_W:0]     d_end;
  logic [COUNT_W:0]     last_bit;
  logic                 zero_len;
  logic                 refused;
  logic signed [COUNT_W-1:0] src_diff;
  logic signed [COUNT_W-1:0] src_byte0;
  logic [AW-1:0]        a0;
  logic [AW-1:0]        k0;
  logic [AW-1:0]        kend;
  logic [2:0]           sh;
  logic [DATA_W-1:0]    first_mask;
  logic [DATA_W-1:0]    last_mask;
  logic [DATA_W-1:0]    mask_k;
  logic                 last_byte;
  logic [2*DATA_W-1:0]  win;
  logic [DATA_W-1:0]    merged;

  logic                 src_wr_en;
  logic                 src_rd_en;
  logic [AW-1:0]        src_rd_addr;
  logic [DATA_W-1:0]    src_rd_data;
  logic                 dst_wr_en;
  logic [AW-1:0]        dst_wr_addr;
  logic [DATA_W-1:0]    dst_wr_data;
  logic                 dst_rd_en;
  logic [AW-1:0]        dst_rd_addr;
  logic [DATA_W-1:0]    dst_rd_data;

  assign in_ok   = {22'd0, in_byte_address} < STORE_LIM;
  assign in_addr = AW'(in_byte_address);

  // Range check on the latched copy.
  assign s_end    = {2'b00, s_r} + {1'b0, n_r};
  assign d_end    = {2'b00, d_r} + {1'b0, n_r};
  assign last_bit = d_end - 15'd1;
  assign zero_len = (n_r == '0);
  assign refused  = ({17'd0, s_end} > TOTAL_BITS) || ({17'd0, d_end} > TOTAL_BITS);

  // Source bit for destination bit 8k+b is 8*a_k + b + sh, with a_k the
  // source byte aligned to destination byte k (may be one below the run).
  assign src_diff  = $signed({1'b0, s_r}) - $signed({11'd0, d_r[2:0]});
  assign src_byte0 = src_diff >>> 3;
  assign a0        = AW'(src_byte0);
  assign sh        = src_diff[2:0];
  assign k0        = AW'(d_r[BIT_IDX_W-1:3]);
  assign kend      = AW'(last_bit[COUNT_W:3]);

  assign first_mask = 8'hFF << d_r[2:0];
  assign last_mask  = 8'hFF >> (3'd7 - last_bit[2:0]);
  assign last_byte  = (k_r == kend);
  assign mask_k     = (first_r ? first_mask : 8'hFF) & (last_byte ? last_mask : 8'hFF);

  assign win    = {src_rd_data, prev_r} >> sh;
  assign merged = (win[DATA_W-1:0] & wr_mask_r) | (dst_rd_data & ~wr_mask_r);

  // Source store ports.
  assign src_wr_en   = cmd.load && (in_func == FUNC_WR_SRC) && in_ok;
  assign src_rd_en   = cmd.prime || cmd.run;
  assign src_rd_addr = cmd.prime ? a0 : a_r;

  // Destination store ports; host accesses and copy write-back never overlap.
  assign dst_wr_en   = wr_v_r || (cmd.load && (in_func == FUNC_WR_DST) && in_ok);
  assign dst_wr_addr = wr_v_r ? wr_k_r : in_addr;
  assign dst_wr_data = wr_v_r ? merged : in_write_data;
  assign dst_rd_en   = cmd.run || (cmd.load && (in_func == FUNC_RD_DST));
  assign dst_rd_addr = cmd.run ? k_r : in_addr;

  bfce_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_src_ram (
    .clk     (clk),
    .wr_en   (src_wr_en),
    .wr_addr (in_addr),
    .wr_data (in_write_data),
    .rd_en   (src_rd_en),
    .rd_addr (src_rd_addr),
    .rd_data (src_rd_data)
  );

  bfce_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_dst_ram (
    .clk     (clk),
    .wr_en   (dst_wr_en),
    .wr_addr (dst_wr_addr),
    .wr_data (dst_wr_data),
    .rd_en   (dst_rd_en),
    .rd_addr (dst_rd_addr),
    .rd_data (dst_rd_data)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_v_r <= cmd.run;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= func_t'(in_func);
      addr_ok_r <= in_ok;
      s_r       <= in_src_bit_index;
      d_r       <= in_dst_bit_index;
      n_r       <= in_bit_count;
    end
    if (cmd.prime) begin
      k_r     <= k0;
      a_r     <= a0 + AW'(1);
      first_r <= 1'b1;
    end
    if (cmd.run) begin
      k_r       <= k_r + AW'(1);
      a_r       <= a_r + AW'(1);
      first_r   <= 1'b0;
      prev_r    <= src_rd_data;
      wr_k_r    <= k_r;
      wr_mask_r <= mask_k;
    end
    if (cmd.finish) begin
      out_read_data_r <= ((func_r == FUNC_RD_DST) && addr_ok_r) ? dst_rd_data : '0;
      out_status_r    <= (func_r == FUNC_COPY) && !zero_len && refused;
    end
  end

  assign sts.is_copy   = (func_r == FUNC_COPY);
  assign sts.zero_len  = zero_len;
  assign sts.refused   = refused;
  assign sts.last_byte = last_byte;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_status    = out_status_r;

endmodule

`default_nettype wire

/* rtl/bit_field_copy_engine.sv */
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       request    in_valid/in_stall  func, byte_address, write_data,
//                                         src_bit_index, dst_bit_index, bit_count
// out_      result     out_valid/out_stall read_data, status
//
// One request is handled at a time. Byte writes, byte reads, empty copies and
// refused copies go from the accept state through the range check to the
// result state, which loads the result register once the output is free.
// A copy that touches B destination bytes adds a priming read, the walk
// over its B bytes and a drain state; the walker moves one destination byte
// per cycle through the single read port of each byte store, and each
// merged byte is written back in the following cycle.
// Reset is synchronous and active low; it clears the controller and the
// valid flags, while the byte stores hold whatever was last written.
// A stalled result waits in the output register; the next request is taken
// as soon as the controller is idle, even while that result waits.

module bit_field_copy_engine #(
  parameter int STORE_BYTES = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_func,
  input  logic [bfce_pkg::ADDR_W-1:0]    in_byte_address,
  input  logic [bfce_pkg::DATA_W-1:0]    in_write_data,
  input  logic [bfce_pkg::BIT_IDX_W-1:0] in_src_bit_index,
  input  logic [bfce_pkg::BIT_IDX_W-1:0] in_dst_bit_index,
  input  logic [bfce_pkg::COUNT_W-1:0]   in_bit_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bfce_pkg::DATA_W-1:0]    out_read_data,
  output logic                           out_status
);

  import bfce_pkg::*;

  // Commands and status between the controller and the datapath.
  bfce_cmd_t cmd;
  bfce_sts_t sts;

  // The controller sequences a request: latch, range check, then for a copy
  // a priming read of the first source byte, the byte walk, and a final
  // write-back before the result is loaded.
  bfce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds both byte stores, the shift-and-merge logic and the
  // result register.
  bfce_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_byte_address  (in_byte_address),
    .in_write_data    (in_write_data),
    .in_src_bit_index (in_src_bit_index),
    .in_dst_bit_index (in_dst_bit_index),
    .in_bit_count     (in_bit_count),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_read_data    (out_read_data),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire

/* rtl/bfce_checker.sv */
`default_nettype none

module bfce_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bfce_pkg::DATA_W-1:0] out_read_data,
  input logic                        out_status
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) && $stable(out_status))
    else $error("stalled result changed");

  // Only one request is in flight: the request side stalls right after an accept.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  // A refused copy never carries read data.
  a_status_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_read_data == '0)
    else $error("refused copy with read data");

  // Reset leaves no result and an idle request side.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("bad state after reset");

endmodule

bind bit_field_copy_engine bfce_checker u_bfce_checker (.*);

`default_nettype wire
